// ===== rtl/core/dss_pkg.sv =====
package dss_pkg;

  // default number of delimiter bytes the block can hold
  localparam int MAX_DELIM_DEF = 8;

  // field and register widths
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int LEN_W      = 4;
  localparam int DELIM_W    = 64;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ON    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_LIMIT = 2'd3;

  // register reset values (newline as a one-byte delimiter)
  localparam logic [LEN_W-1:0]   DELIM_LEN_RST   = 4'd1;
  localparam logic [DELIM_W-1:0] DELIM_BYTES_RST = 64'd10;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA       = 2'd0,
    KIND_TOKEN_END  = 2'd1,
    KIND_STRING_END = 2'd2
  } kind_t;

  // where an emitted result comes from
  typedef enum logic [1:0] {
    SRC_HELD   = 2'd0,
    SRC_BYTE   = 2'd1,
    SRC_TOKEN  = 2'd2,
    SRC_STRING = 2'd3
  } src_t;

  // result segments that one input transaction produces, in emission order
  typedef struct packed {
    logic has_pre;
    logic has_data;
    logic has_tok;
    logic has_post;
    logic has_etok;
    logic has_str;
  } plan_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic emit;
    src_t src;
    logic last;
    logic idx_inc;
    logic idx_clr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    plan_t plan_now;
    plan_t plan_r;
    logic  pre_last;
    logic  post_last;
    logic  slot_free;
  } sts_t;

  // delimiter byte i, byte zero in the low bits
  function automatic logic [BYTE_W-1:0] delim_byte(input logic [DELIM_W-1:0] d,
                                                   input logic [3:0] i);
    return d[{i[2:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

// ===== rtl/core/delimiter_stream_splitter.sv =====
// Byte stream tokenizer: each input transaction carries one byte with tlast
// marking the end of a string; results are data bytes, token-end and
// string-end markers (tuser kind 0, 1, 2), with tlast on the last result that
// an input caused. The delimiter (up to MAX_DELIM bytes), its length, and an
// optional per-string split limit are to be set over the cfg port only while
// the block is idle; the block itself does not enforce this. An input byte
// produces n results, n from 0 to MAX_DELIM + 2: the sequencer takes the byte
// while idle, then emits its results one at a time through the single output
// register, and takes no new byte until the last of them is in that register.
// A stalled output holds the sequencer on the current result.
module delimiter_stream_splitter #(
  parameter int MAX_DELIM = dss_pkg::MAX_DELIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,   // end_of_string
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_byte
  output logic [1:0]                     out_tuser,  // [1:0] kind
  output logic                           out_tlast   // run_last
);
  import dss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // match logic, state and output register
  dss_datapath #(
    .MAX_DELIM (MAX_DELIM)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_tdata),
    .in_eos    (in_tlast),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_kind  (out_tuser),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/core/dss_datapath.sv =====
module dss_datapath #(
  parameter int MAX_DELIM = dss_pkg::MAX_DELIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [dss_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           in_eos,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [dss_pkg::KIND_W-1:0]     out_kind,
  output logic [dss_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_last,
  input  dss_pkg::cmd_t                  cmd,
  output dss_pkg::sts_t                  sts
);
  import dss_pkg::*;

  localparam int HELD_W = $clog2(MAX_DELIM + 1);
  localparam logic [LIMIT_W-1:0] SPLIT_MAX = '1;

  // configuration registers
  logic [LEN_W-1:0]   delim_len_r;
  logic [DELIM_W-1:0] delim_bytes_r;
  logic               limit_on_r;
  logic [LIMIT_W-1:0] split_limit_r;

  // tokenizer state
  logic [HELD_W-1:0]  match_pos_r;
  logic               token_open_r;
  logic [LIMIT_W-1:0] splits_done_r;

  // plan of the transaction in progress
  plan_t              plan_r;
  logic [HELD_W-1:0]  pre_cnt_r;
  logic [HELD_W-1:0]  post_cnt_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [HELD_W-1:0]  idx_r;
  logic [HELD_W-1:0]  idx_nxt;

  // result register
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_last_r;

  // accept-time decisions
  logic [HELD_W-1:0]  eff;
  logic               eff_zero;
  logic               allowed;
  logic               hit_held;
  logic               pre_flush;
  logic [HELD_W-1:0]  h0;
  logic [HELD_W-1:0]  h1;
  logic               match;
  logic               complete;
  logic [HELD_W-1:0]  post_held;
  logic               open1;
  logic               open2;
  plan_t              plan_now;
  kind_t              res_kind;
  logic [BYTE_W-1:0]  res_byte;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_len_r   <= DELIM_LEN_RST;
      delim_bytes_r <= DELIM_BYTES_RST;
      limit_on_r    <= 1'b0;
      split_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DELIM_LEN:   delim_len_r   <= cfg_wdata[LEN_W-1:0];
        CFG_DELIM_BYTES: delim_bytes_r <= cfg_wdata[DELIM_W-1:0];
        CFG_LIMIT_ON:    limit_on_r    <= cfg_wdata[0];
        CFG_SPLIT_LIMIT: split_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // match decisions for the incoming byte
  always_comb begin
    if (delim_len_r > LEN_W'(MAX_DELIM)) begin
      eff = HELD_W'(MAX_DELIM);
    end else begin
      eff = HELD_W'(delim_len_r);
    end
    eff_zero  = (eff == '0);
    allowed   = !limit_on_r || (splits_done_r < split_limit_r);
    hit_held  = allowed && (delim_byte(delim_bytes_r, 4'(match_pos_r)) == in_byte);
    pre_flush = (match_pos_r != '0) &&
                ((match_pos_r >= eff) || (!eff_zero && !hit_held));
    h0        = pre_flush ? '0 : match_pos_r;
    match     = !eff_zero && allowed && (delim_byte(delim_bytes_r, 4'(h0)) == in_byte);
    h1        = h0 + HELD_W'(1);
    complete  = match && (h1 >= eff);
    post_held = (match && !complete) ? h1 : '0;
    open1     = token_open_r || pre_flush;

    plan_now.has_pre  = pre_flush;
    plan_now.has_data = eff_zero || !match;
    plan_now.has_tok  = eff_zero || (complete && open1);
    if (eff_zero || complete) begin
      open2 = 1'b0;
    end else begin
      open2 = plan_now.has_data || open1;
    end
    plan_now.has_post = in_eos && (post_held != '0);
    plan_now.has_etok = in_eos && (open2 || (post_held != '0));
    plan_now.has_str  = in_eos;
  end

  // state update and plan capture at input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_pos_r   <= '0;
      token_open_r  <= 1'b0;
      splits_done_r <= '0;
      plan_r        <= '0;
    end else if (cmd.accept) begin
      plan_r <= plan_now;
      if (in_eos) begin
        match_pos_r   <= '0;
        token_open_r  <= 1'b0;
        splits_done_r <= '0;
      end else begin
        match_pos_r  <= post_held;
        token_open_r <= open2;
        if (complete && (splits_done_r != SPLIT_MAX)) begin
          splits_done_r <= splits_done_r + LIMIT_W'(1);
        end
      end
    end
  end

  // plan payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pre_cnt_r  <= match_pos_r;
      post_cnt_r <= post_held;
      byte_r     <= in_byte;
    end
  end

  // held byte index for flushes
  assign idx_nxt = idx_r + HELD_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_nxt;
    end
  end

  // result selection
  always_comb begin
    case (cmd.src)
      SRC_HELD: begin
        res_kind = KIND_DATA;
        res_byte = delim_byte(delim_bytes_r, 4'(idx_r));
      end
      SRC_BYTE: begin
        res_kind = KIND_DATA;
        res_byte = byte_r;
      end
      SRC_TOKEN: begin
        res_kind = KIND_TOKEN_END;
        res_byte = '0;
      end
      SRC_STRING: begin
        res_kind = KIND_STRING_END;
        res_byte = '0;
      end
      default: begin
        res_kind = KIND_DATA;
        res_byte = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // status to the controller
  assign sts.plan_now  = plan_now;
  assign sts.plan_r    = plan_r;
  assign sts.pre_last  = (idx_nxt == pre_cnt_r);
  assign sts.post_last = (idx_nxt == post_cnt_r);
  assign sts.slot_free = !out_valid_r || out_ready;

  // checks
  a_marker_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r != KIND_DATA) |-> out_byte_r == '0)
    else $error("marker result carries a nonzero byte");

  a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    match_pos_r < HELD_W'(MAX_DELIM))
    else $error("held delimiter count out of range");

  a_string_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_STRING_END) |-> out_last_r)
    else $error("string end is not the last result of its transaction");

endmodule

// ===== rtl/core/dss_ctrl.sv =====
module dss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dss_pkg::sts_t sts,
  output dss_pkg::cmd_t cmd
);
  import dss_pkg::*;

  // states follow the emission order of the segments
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_PRE  = 3'd1,
    ST_DATA = 3'd2,
    ST_TOK  = 3'd3,
    ST_POST = 3'd4,
    ST_ETOK = 3'd5,
    ST_STR  = 3'd6
  } state_t;

  state_t state_r;
  state_t state_nxt;
  state_t following;
  logic   seg_end;

  // first segment present after state s
  function automatic state_t next_after(input state_t s, input plan_t p);
    state_t r;
    r = ST_IDLE;
    if (p.has_str  && (s < ST_STR))  r = ST_STR;
    if (p.has_etok && (s < ST_ETOK)) r = ST_ETOK;
    if (p.has_post && (s < ST_POST)) r = ST_POST;
    if (p.has_tok  && (s < ST_TOK))  r = ST_TOK;
    if (p.has_data && (s < ST_DATA)) r = ST_DATA;
    if (p.has_pre  && (s < ST_PRE))  r = ST_PRE;
    return r;
  endfunction

  // sequencing of results
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    cmd.accept  = in_ready && in_valid;
    cmd.emit    = (state_r != ST_IDLE) && sts.slot_free;
    following   = next_after(state_r, sts.plan_r);
    seg_end     = 1'b1;
    cmd.src     = SRC_BYTE;
    case (state_r)
      ST_PRE: begin
        seg_end = sts.pre_last;
        cmd.src = SRC_HELD;
      end
      ST_POST: begin
        seg_end = sts.post_last;
        cmd.src = SRC_HELD;
      end
      ST_TOK, ST_ETOK: cmd.src = SRC_TOKEN;
      ST_STR:          cmd.src = SRC_STRING;
      default:         cmd.src = SRC_BYTE;
    endcase
    cmd.last    = seg_end && (following == ST_IDLE);
    cmd.idx_inc = cmd.emit && !seg_end;
    cmd.idx_clr = cmd.accept || (cmd.emit && seg_end);

    if (state_r == ST_IDLE) begin
      state_nxt = cmd.accept ? next_after(ST_IDLE, sts.plan_now) : ST_IDLE;
    end else if (cmd.emit && seg_end) begin
      state_nxt = following;
    end else begin
      state_nxt = state_r;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.slot_free)
    else $error("result emitted into an occupied output register");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.last |=> state_r == ST_IDLE)
    else $error("sequencer still busy after the last result");

  a_empty_plan_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && (sts.plan_now == '0) |=> state_r == ST_IDLE)
    else $error("transaction without results left the sequencer busy");

endmodule

// ===== tb/sv/delimiter_stream_splitter_tb.sv =====
module delimiter_stream_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  localparam int DELIM_SLOTS = MAX_DELIM_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  // predictor copy of the registers and the tokenizer state
  logic [3:0]  delim_len_q;
  logic [63:0] delim_q;
  logic        limit_en_q;
  logic [15:0] limit_max_q;
  logic [3:0]  held_q;
  logic        token_q;
  logic [15:0] splits_q;

  result_t result_due[$];
  int      emitted;
  int      mismatches = 0;
  int      cycle_cnt = 0;
  int      hold_off_len = 0;
  bit      src_gaps = 1'b1;
  bit      sink_stalls = 1'b1;

  delimiter_stream_splitter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tokenizer predictor

  function automatic logic [7:0] delim_char(int unsigned i);
    return delim_q[8*(i % 8) +: 8];
  endfunction

  function automatic void push_result(kind_t k, logic [7:0] b);
    result_t r;
    r.kind = k;
    r.data = b;
    r.last = 1'b0;
    result_due.insert(result_due.size(), r);
    emitted++;
    if (k == KIND_DATA) token_q = 1'b1;
  endfunction

  // held match bytes go out as plain data
  function automatic void flush_match(int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_result(KIND_DATA, delim_char(i));
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic eos);
    int unsigned eff;
    int unsigned held;
    bit          open_ok;
    emitted = 0;
    eff  = (delim_len_q > DELIM_SLOTS) ? DELIM_SLOTS : delim_len_q;
    held = (held_q > DELIM_SLOTS - 1) ? DELIM_SLOTS - 1 : held_q;
    // delimiter shortened while bytes were held
    if (held > 0 && held >= eff) begin
      flush_match(held);
      held = 0;
    end
    if (eff == 0) begin
      push_result(KIND_DATA, b);
      push_result(KIND_TOKEN_END, 8'h00);
      token_q = 1'b0;
    end else begin
      open_ok = !limit_en_q || splits_q < limit_max_q;
      // broken partial match, the byte may still start a new one
      if (held > 0 && !(open_ok && delim_char(held) == b)) begin
        flush_match(held);
        held = 0;
      end
      if (open_ok && delim_char(held) == b) begin
        held++;
        if (held >= eff) begin
          if (token_q) push_result(KIND_TOKEN_END, 8'h00);
          token_q = 1'b0;
          held = 0;
          if (splits_q != 16'hFFFF) splits_q++;
        end
      end else begin
        push_result(KIND_DATA, b);
      end
    end
    if (eos) begin
      flush_match(held);
      held = 0;
      if (token_q) push_result(KIND_TOKEN_END, 8'h00);
      push_result(KIND_STRING_END, 8'h00);
      token_q  = 1'b0;
      splits_q = 16'd0;
    end
    held_q = 4'(held);
    // mark the last result of this byte
    if (emitted > 0) begin
      result_due[result_due.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checker

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_due.size() == 0) begin
        $error("unexpected result transaction: kind %0d out_byte 0x%02h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = result_due.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          mismatches++;
        end
        if (out_tdata !== want.data) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_tdata);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("run_last: expected %0d, got %0d", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // result side ready: random stalls and requested long hold-offs
  initial begin : sink_ready
    int n;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared drivers

  // one input transaction, predicted once accepted
  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    tokenize_byte(b, eos);
  endtask

  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
  endtask

  // stop sending, drain results, let zero-result bytes finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (result_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all four registers back to back
  task automatic write_config(logic [3:0] len, logic [63:0] delim, logic lim_on,
                              logic [15:0] lim);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DELIM_LEN;
    cfg_wdata <= 64'(len);
    @(posedge clk);
    cfg_addr  <= CFG_DELIM_BYTES;
    cfg_wdata <= delim;
    @(posedge clk);
    cfg_addr  <= CFG_LIMIT_ON;
    cfg_wdata <= 64'(lim_on);
    @(posedge clk);
    cfg_addr  <= CFG_SPLIT_LIMIT;
    cfg_wdata <= 64'(lim);
    @(posedge clk);
    cfg_we <= 1'b0;
    delim_len_q = len;
    delim_q     = delim;
    limit_en_q  = lim_on;
    limit_max_q = lim;
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // reset config: newline delimiter, leading and repeated delimiters, byte extremes
  task automatic test_default_newline();
    send_text("\na\n\n", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // delimiter "aab": broken match restarts on the same byte, held bytes at string end
  task automatic test_partial_match();
    wait_idle();
    write_config(4'd3, 64'h0000_0000_0062_6161, 1'b0, 16'd0);
    send_text("xaaaaba", 1'b1);
  endtask

  // length above the slot count acts as full width, bytes 00 and FF in the delimiter
  task automatic test_wide_delimiter();
    wait_idle();
    write_config(4'd15, 64'hFF00_FF00_FF00_FF00, 1'b0, 16'd0);
    send_byte("q", 1'b0);
    for (int i = 0; i < 8; i++) send_byte((i % 2) ? 8'hFF : 8'h00, 1'b0);
    send_byte("r", 1'b1);
  endtask

  // zero-length delimiter: each byte is a token
  task automatic test_zero_length();
    wait_idle();
    write_config(4'd0, 64'h0000_0000_0000_002C, 1'b0, 16'd0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);
  endtask

  // one split allowed, the second comma passes as data
  task automatic test_split_limit();
    wait_idle();
    write_config(4'd1, 64'h0000_0000_0000_002C, 1'b1, 16'd1);
    send_text("a,b,c", 1'b1);
  endtask

  // "abc" with two bytes held, then shortened to "xy" while idle
  task automatic test_reconfig_mid_match();
    wait_idle();
    write_config(4'd3, 64'h0000_0000_0063_6261, 1'b0, 16'd0);
    send_text("ab", 1'b0);
    wait_idle();
    write_config(4'd2, 64'h0000_0000_0063_7978, 1'b0, 16'd0);
    send_byte("z", 1'b1);
  endtask

  // random strings built mostly from the delimiter's own bytes
  task automatic test_random_text(int n_items, bit idles);
    logic [3:0]  len;
    logic [63:0] delim;
    logic [7:0]  a, b, ch;
    logic        lim_on;
    logic [15:0] lim;
    int          sent, str_len, span, idx;
    wait_idle();
    src_gaps    = idles;
    sink_stalls = idles;
    case ($urandom_range(0, 9))
      0: len = 4'd0;
      1: len = 4'($urandom_range(9, 15));
      2: len = 4'd8;
      default: len = 4'($urandom_range(1, 4));
    endcase
    a = 8'($urandom);
    b = 8'($urandom);
    delim = {$urandom, $urandom};
    // two-letter delimiters give self-overlapping patterns
    if ($urandom_range(0, 3) != 0)
      for (int k = 0; k < 8; k++) delim[8*k +: 8] = $urandom_range(0, 1) ? a : b;
    lim_on = 1'($urandom_range(0, 1));
    lim = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
    write_config(len, delim, lim_on, lim);
    span = (len == 0) ? 1 : ((len > DELIM_SLOTS) ? DELIM_SLOTS : int'(len));
    sent = 0;
    while (sent < n_items) begin
      str_len = $urandom_range(1, 14);
      for (int k = 0; k < str_len && sent < n_items; k++) begin
        if ($urandom_range(0, 9) < 6) begin
          idx = $urandom_range(0, span - 1);
          ch  = delim[8*idx +: 8];
        end else begin
          ch = 8'($urandom);
        end
        send_byte(ch, k == str_len - 1);
        sent++;
      end
    end
  endtask

  // long output hold-off while bytes keep coming
  task automatic test_output_backpressure();
    wait_idle();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    write_config(4'd0, 64'h0, 1'b0, 16'd0);
    hold_off_len = 300;
    for (int k = 0; k < 40; k++) send_byte(8'($urandom), k % 10 == 9);
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_DELIM_LEN;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    delim_len_q = DELIM_LEN_RST;
    delim_q     = DELIM_BYTES_RST;
    limit_en_q  = 1'b0;
    limit_max_q = 16'd0;
    held_q      = 4'd0;
    token_q     = 1'b0;
    splits_q    = 16'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_newline();
    test_partial_match();
    test_wide_delimiter();
    test_zero_length();
    test_split_limit();
    test_reconfig_mid_match();
    for (int p = 0; p < 8; p++) test_random_text(36, 1'b1);
    test_output_backpressure();
    // closing stretch without idling
    test_random_text(36, 1'b0);
    test_random_text(36, 1'b0);
    wait_idle();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
